// ===== hdl/bvrp_pkg.sv =====
package bvrp_pkg;

  localparam int MEM_BYTES = 8192;
  localparam int MAP_TILES = 2048;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int TILE_AW   = $clog2(MAP_TILES);

  localparam logic [MEM_AW-1:0]  PAL_END     = 13'h0800;
  localparam logic [MEM_AW-1:0]  TILE_BASE   = 13'h1000;
  localparam logic [TILE_AW-1:0] PAL_HI_OFS  = 11'h400;
  localparam logic [4:0]         COMP_MASK   = 5'h1f;
  localparam logic [5:0]         BG_MASK     = 6'h07;
  localparam logic [5:0]         TEXT_MASK   = 6'h3f;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_BANK  = 2'd2,
    CMD_FETCH = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    RSEL_OFF     = 3'd0,
    RSEL_PAIR    = 3'd1,
    RSEL_CODE_LO = 3'd2,
    RSEL_CODE_HI = 3'd3,
    RSEL_COLOR   = 3'd4
  } rsel_t;

  typedef struct packed {
    logic  ld_req;
    logic  clr;
    logic  wr;
    logic  bank_we;
    rsel_t rsel;
    logic  cap_lo;
    logic  cap_hi;
    logic  cap_last;
    logic  load_out;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic is_pal;
    logic clr_last;
    logic out_free;
  } st_t;

endpackage

// ===== hdl/bvrp_ram.sv =====
module bvrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bvrp_ctrl.sv =====
module bvrp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bvrp_pkg::st_t  st,
  output bvrp_pkg::ctl_t ctl
);

  import bvrp_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_ISSUE = 7'b0000100,
    S_F1    = 7'b0001000,
    S_F2    = 7'b0010000,
    S_CAP   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    ctl       = '0;
    ctl.rsel  = RSEL_OFF;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        ctl.clr = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.ld_req = 1'b1;
          state_nxt  = S_ISSUE;
        end
      end
      S_ISSUE: begin
        case (st.cmd)
          CMD_READ: begin
            ctl.rsel  = RSEL_OFF;
            state_nxt = S_CAP;
          end
          CMD_WRITE: begin
            ctl.wr = 1'b1;
            // The neighbor byte is read while the new byte is stored.
            if (st.is_pal) begin
              ctl.rsel  = RSEL_PAIR;
              state_nxt = S_CAP;
            end else begin
              state_nxt = S_DONE;
            end
          end
          CMD_BANK: begin
            ctl.bank_we = 1'b1;
            state_nxt   = S_DONE;
          end
          CMD_FETCH: begin
            ctl.rsel  = RSEL_CODE_LO;
            state_nxt = S_F1;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_F1: begin
        ctl.rsel   = RSEL_CODE_HI;
        ctl.cap_lo = 1'b1;
        state_nxt  = S_F2;
      end
      S_F2: begin
        ctl.rsel   = RSEL_COLOR;
        ctl.cap_hi = 1'b1;
        state_nxt  = S_CAP;
      end
      S_CAP: begin
        ctl.cap_last = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_ISSUE && !in_ready))
    else $error("accepted request did not move to issue");

  a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && st.clr_last) |=> (in_ready && !ctl.clr))
    else $error("clearing pass did not end at the last address");

  a_fetch_order: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.cap_hi |-> $past(ctl.cap_lo))
    else $error("tile code high byte captured out of order");

endmodule

// ===== hdl/bvrp_dpath.sv =====
module bvrp_dpath (
  input  logic           clk,
  input  logic           rst_n,
  input  bvrp_pkg::ctl_t ctl,
  output bvrp_pkg::st_t  st,
  input  logic [1:0]     in_cmd,
  input  logic [12:0]    in_offset,
  input  logic [7:0]     in_data,
  input  logic           in_fetch_layer,
  input  logic [10:0]    in_tile_index,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_read_data,
  output logic           out_pal_valid,
  output logic [10:0]    out_pal_index,
  output logic [7:0]     out_red,
  output logic [7:0]     out_green,
  output logic [7:0]     out_blue,
  output logic           out_dirty_valid,
  output logic           out_dirty_layer,
  output logic [10:0]    out_dirty_tile,
  output logic [15:0]    out_tile_code,
  output logic [5:0]     out_tile_color
);

  import bvrp_pkg::*;

  function automatic logic [7:0] expand5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  cmd_t               cmd_r;
  logic [MEM_AW-1:0]  off_r;
  logic [7:0]         data_r;
  logic               layer_r;
  logic [TILE_AW-1:0] idx_r;
  logic [1:0]         bank_r;
  logic [MEM_AW-1:0]  clr_cnt_r;
  logic [7:0]         lo_r, hi_r, last_r;
  logic               out_valid_r;

  logic               is_pal, area_sel_a, rd_sel_a;
  logic               we_a, we_b;
  logic [MEM_AW-1:0]  waddr, raddr;
  logic [7:0]         wdata, rdata_a, rdata_b, rdata;

  assign is_pal     = (off_r < PAL_END);
  assign area_sel_a = is_pal ? bank_r[1] : bank_r[0];
  assign rd_sel_a   = (cmd_r == CMD_FETCH) ? !layer_r : area_sel_a;

  assign we_a  = ctl.clr || (ctl.wr && area_sel_a);
  assign we_b  = ctl.clr || (ctl.wr && !area_sel_a);
  assign waddr = ctl.clr ? clr_cnt_r : off_r;
  assign wdata = ctl.clr ? 8'd0 : data_r;
  assign rdata = rd_sel_a ? rdata_a : rdata_b;

  always_comb begin
    case (ctl.rsel)
      RSEL_OFF:     raddr = off_r;
      RSEL_PAIR:    raddr = off_r ^ MEM_AW'(1);
      RSEL_CODE_LO: raddr = TILE_BASE + {1'b0, idx_r, 1'b0};
      RSEL_CODE_HI: raddr = TILE_BASE + {1'b0, idx_r, 1'b1};
      RSEL_COLOR:   raddr = PAL_END + MEM_AW'(idx_r);
      default:      raddr = off_r;
    endcase
  end

  bvrp_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_a)
  );

  bvrp_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_b)
  );

  assign st.cmd      = cmd_r;
  assign st.is_pal   = is_pal;
  assign st.clr_last = (clr_cnt_r == MEM_AW'(MEM_BYTES - 1));
  assign st.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (ctl.ld_req) begin
      cmd_r   <= cmd_t'(in_cmd);
      off_r   <= in_offset;
      data_r  <= in_data;
      layer_r <= in_fetch_layer;
      idx_r   <= in_tile_index;
    end
    if (ctl.cap_lo)   lo_r   <= rdata;
    if (ctl.cap_hi)   hi_r   <= rdata;
    if (ctl.cap_last) last_r <= rdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r    <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (ctl.bank_we) bank_r <= data_r[1:0];
      if (ctl.clr) clr_cnt_r <= clr_cnt_r + MEM_AW'(1);
    end
  end

  // Result assembly; the palette pair holds the new byte on its own side.
  logic [7:0]        pal_lo, pal_hi;
  logic [15:0]       color;
  logic [MEM_AW-1:0] col_rel, tile_rel;
  logic [7:0]        res_read;
  logic              res_pvalid, res_dvalid, res_dlayer;
  logic [10:0]       res_pindex, res_dtile;
  logic [7:0]        res_red, res_green, res_blue;
  logic [15:0]       res_code;
  logic [5:0]        res_color;

  always_comb begin
    pal_lo   = off_r[0] ? last_r : data_r;
    pal_hi   = off_r[0] ? data_r : last_r;
    color    = {pal_hi, pal_lo};
    col_rel  = off_r - PAL_END;
    tile_rel = (off_r - TILE_BASE) >> 1;

    res_read   = '0;
    res_pvalid = 1'b0;
    res_pindex = '0;
    res_red    = '0;
    res_green  = '0;
    res_blue   = '0;
    res_dvalid = 1'b0;
    res_dlayer = 1'b0;
    res_dtile  = '0;
    res_code   = '0;
    res_color  = '0;
    case (cmd_r)
      CMD_READ: res_read = last_r;
      CMD_WRITE: begin
        if (is_pal) begin
          res_pvalid = 1'b1;
          res_pindex = 11'(off_r[10:1]) + (bank_r[1] ? PAL_HI_OFS : 11'd0);
          res_red    = expand5(color[4:0] & COMP_MASK);
          res_green  = expand5(color[9:5] & COMP_MASK);
          res_blue   = expand5(color[14:10] & COMP_MASK);
        end else begin
          res_dvalid = 1'b1;
          res_dlayer = !bank_r[0];
          res_dtile  = (off_r < TILE_BASE) ? col_rel[10:0] : tile_rel[10:0];
        end
      end
      CMD_FETCH: begin
        res_code  = {hi_r, lo_r};
        res_color = last_r[5:0] & (layer_r ? TEXT_MASK : BG_MASK);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_read_data   <= res_read;
      out_pal_valid   <= res_pvalid;
      out_pal_index   <= res_pindex;
      out_red         <= res_red;
      out_green       <= res_green;
      out_blue        <= res_blue;
      out_dirty_valid <= res_dvalid;
      out_dirty_layer <= res_dlayer;
      out_dirty_tile  <= res_dtile;
      out_tile_code   <= res_code;
      out_tile_color  <= res_color;
    end
  end

  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over an unaccepted result");

  a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |-> (!ctl.wr && !ctl.ld_req && !out_valid_r))
    else $error("request activity during the clearing pass");

  a_one_bank: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr |-> (we_a != we_b))
    else $error("bus write reached both or neither memory");

endmodule

// ===== hdl/banked_video_ram_palette.sv =====
// Path: tile and bank writes go from the issue state to the done state; bus reads and
// palette writes add a capture state; tile fetches add F1, F2 and capture (three reads
// on one RAM read port). Flow: one request at a time, the controller visiting its states
// once per request; a held result only stalls the following request at its last step.
// Reset: synchronous, active low. After reset both memories are cleared, one address a
// cycle, all 8192 addresses with in_ready low; the bank register resets to zero.
module banked_video_ram_palette (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [12:0] in_offset,
  input  logic [7:0]  in_data,
  input  logic        in_fetch_layer,
  input  logic [10:0] in_tile_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic        out_pal_valid,
  output logic [10:0] out_pal_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_dirty_valid,
  output logic        out_dirty_layer,
  output logic [10:0] out_dirty_tile,
  output logic [15:0] out_tile_code,
  output logic [5:0]  out_tile_color
);

  import bvrp_pkg::*;

  ctl_t ctl;
  st_t  st;

  bvrp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .ctl      (ctl)
  );

  bvrp_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .st              (st),
    .in_cmd          (in_cmd),
    .in_offset       (in_offset),
    .in_data         (in_data),
    .in_fetch_layer  (in_fetch_layer),
    .in_tile_index   (in_tile_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_data   (out_read_data),
    .out_pal_valid   (out_pal_valid),
    .out_pal_index   (out_pal_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_dirty_valid (out_dirty_valid),
    .out_dirty_layer (out_dirty_layer),
    .out_dirty_tile  (out_dirty_tile),
    .out_tile_code   (out_tile_code),
    .out_tile_color  (out_tile_color)
  );

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import bvrp_pkg::*;

  typedef struct packed {
    cmd_t               cmd;
    logic [MEM_AW-1:0]  offset;
    logic [7:0]         data;
    logic               layer;
    logic [TILE_AW-1:0] tile;
  } vram_req_t;

  typedef struct packed {
    logic [7:0]         read_data;
    logic               pal_valid;
    logic [TILE_AW-1:0] pal_index;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               dirty_valid;
    logic               dirty_layer;
    logic [TILE_AW-1:0] dirty_tile;
    logic [15:0]        tile_code;
    logic [5:0]         tile_color;
  } vram_rsp_t;

  typedef struct {
    vram_req_t req;
    bit        typed;
    vram_rsp_t rsp;
  } table_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic [12:0] in_offset;
  logic [7:0]  in_data;
  logic        in_fetch_layer;
  logic [10:0] in_tile_index;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_read_data;
  logic        out_pal_valid;
  logic [10:0] out_pal_index;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_dirty_valid;
  logic        out_dirty_layer;
  logic [10:0] out_dirty_tile;
  logic [15:0] out_tile_code;
  logic [5:0]  out_tile_color;

  // Shadow copy of the block's state.
  logic [7:0] shadow_bank;
  logic [7:0] shadow_a [MEM_BYTES];
  logic [7:0] shadow_b [MEM_BYTES];

  vram_rsp_t          due_responses[$];
  table_row_t         directed_rows[$];
  logic [TILE_AW-1:0] tile_pool[8];
  bit                 idle_off;
  int                 fail_count;

  banked_video_ram_palette u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_offset      (in_offset),
    .in_data        (in_data),
    .in_fetch_layer (in_fetch_layer),
    .in_tile_index  (in_tile_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_pal_valid  (out_pal_valid),
    .out_pal_index  (out_pal_index),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_dirty_valid(out_dirty_valid),
    .out_dirty_layer(out_dirty_layer),
    .out_dirty_tile (out_dirty_tile),
    .out_tile_code  (out_tile_code),
    .out_tile_color (out_tile_color)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic [7:0] expand5(logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  // A set select bit picks memory A.
  function automatic logic [7:0] shadow_rd(logic sel_a, logic [MEM_AW-1:0] addr);
    return sel_a ? shadow_a[addr] : shadow_b[addr];
  endfunction

  function automatic void shadow_wr(logic sel_a, logic [MEM_AW-1:0] addr, logic [7:0] d);
    if (sel_a) begin
      shadow_a[addr] = d;
    end else begin
      shadow_b[addr] = d;
    end
  endfunction

  function automatic vram_rsp_t vram_access(vram_req_t r);
    vram_rsp_t          rsp;
    logic [14:0]        word;
    logic               sel;
    logic [MEM_AW-1:0]  addr;
    logic [MEM_AW-1:0]  rel;
    logic [7:0]         col_byte;
    rsp = '0;
    case (r.cmd)
      CMD_READ: begin
        sel = (r.offset < PAL_END) ? shadow_bank[1] : shadow_bank[0];
        rsp.read_data = shadow_rd(sel, r.offset);
      end
      CMD_WRITE: begin
        if (r.offset < PAL_END) begin
          sel = shadow_bank[1];
          shadow_wr(sel, r.offset, r.data);
          // The pair is read after the store, so the new byte is part of the word.
          word = 15'({shadow_rd(sel, {r.offset[12:1], 1'b1}),
                      shadow_rd(sel, {r.offset[12:1], 1'b0})});
          rsp.pal_valid = 1'b1;
          rsp.pal_index = {1'b0, r.offset[10:1]} + (sel ? PAL_HI_OFS : '0);
          rsp.red       = expand5(word[4:0]);
          rsp.green     = expand5(word[9:5]);
          rsp.blue      = expand5(word[14:10]);
        end else begin
          if (r.offset < TILE_BASE) begin
            rel = r.offset - PAL_END;
          end else begin
            rel = (r.offset - TILE_BASE) >> 1;
          end
          shadow_wr(shadow_bank[0], r.offset, r.data);
          rsp.dirty_valid = 1'b1;
          rsp.dirty_layer = ~shadow_bank[0];
          rsp.dirty_tile  = rel[TILE_AW-1:0];
        end
      end
      CMD_BANK: begin
        shadow_bank = r.data;
      end
      default: begin
        // Background fetches come from memory A, text fetches from memory B.
        addr = TILE_BASE + MEM_AW'({r.tile, 1'b0});
        rsp.tile_code  = {shadow_rd(~r.layer, addr + MEM_AW'(1)), shadow_rd(~r.layer, addr)};
        col_byte       = shadow_rd(~r.layer, PAL_END + MEM_AW'(r.tile));
        rsp.tile_color = col_byte[5:0] & (r.layer ? TEXT_MASK : BG_MASK);
      end
    endcase
    return rsp;
  endfunction

  function automatic vram_rsp_t dirty_rsp(logic layer, logic [TILE_AW-1:0] tile);
    vram_rsp_t rsp;
    rsp = '0;
    rsp.dirty_valid = 1'b1;
    rsp.dirty_layer = layer;
    rsp.dirty_tile  = tile;
    return rsp;
  endfunction

  function automatic void add_row(cmd_t cmd, logic [12:0] off, logic [7:0] d, logic layer,
                                  logic [10:0] tile, bit typed, vram_rsp_t rsp);
    table_row_t row;
    row.req.cmd    = cmd;
    row.req.offset = off;
    row.req.data   = d;
    row.req.layer  = layer;
    row.req.tile   = tile;
    row.typed      = typed;
    row.rsp        = rsp;
    directed_rows.push_back(row);
  endfunction

  // Offsets are biased toward a few tiles so that fetches see what was written.
  function automatic logic [MEM_AW-1:0] pick_offset();
    int                 sel;
    logic [TILE_AW-1:0] t;
    sel = $urandom_range(0, 99);
    t   = tile_pool[$urandom_range(0, 7)];
    if (sel < 20) begin
      return MEM_AW'($urandom_range(0, MEM_BYTES - 1));
    end else if (sel < 45) begin
      if ($urandom_range(0, 1)) begin
        return MEM_AW'($urandom_range(0, PAL_END - 1));
      end
      return {2'b00, t[9:0], 1'($urandom_range(0, 1))};
    end else if (sel < 70) begin
      return PAL_END + MEM_AW'(t);
    end
    return TILE_BASE + MEM_AW'({t, 1'($urandom_range(0, 1))});
  endfunction

  function automatic vram_req_t random_req();
    vram_req_t r;
    int        sel;
    r.cmd    = CMD_READ;
    r.offset = MEM_AW'($urandom_range(0, MEM_BYTES - 1));
    r.data   = 8'($urandom_range(0, 255));
    r.layer  = 1'($urandom_range(0, 1));
    r.tile   = TILE_AW'($urandom_range(0, MAP_TILES - 1));
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      r.cmd = CMD_BANK;
    end else if (sel < 30) begin
      r.offset = pick_offset();
    end else if (sel < 65) begin
      r.cmd    = CMD_WRITE;
      r.offset = pick_offset();
    end else begin
      r.cmd = CMD_FETCH;
      if ($urandom_range(0, 3) != 0) begin
        r.tile = tile_pool[$urandom_range(0, 7)];
      end
    end
    return r;
  endfunction

  task automatic send_request(vram_req_t r, bit typed, vram_rsp_t typed_rsp);
    int        gap;
    vram_rsp_t rsp;
    gap = idle_off ? 0 : $urandom_range(0, 16);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_cmd         <= r.cmd;
    in_offset      <= r.offset;
    in_data        <= r.data;
    in_fetch_layer <= r.layer;
    in_tile_index  <= r.tile;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rsp = vram_access(r);
    due_responses.push_back(typed ? typed_rsp : rsp);
  endtask

  // The last request is withdrawn first so that it is not taken again.
  task automatic drain_responses();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_responses.size() != 0) @(posedge clk);
  endtask

  function automatic string rsp_text(vram_rsp_t x);
    return $sformatf("rd=%h pv=%b pi=%h rgb=%h/%h/%h dv=%b dl=%b dt=%h code=%h col=%h",
                     x.read_data, x.pal_valid, x.pal_index, x.red, x.green, x.blue,
                     x.dirty_valid, x.dirty_layer, x.dirty_tile, x.tile_code, x.tile_color);
  endfunction

  task automatic check_response(vram_rsp_t got);
    vram_rsp_t want;
    bit        bad;
    if (due_responses.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("ERROR: result with no request outstanding: %s", rsp_text(got));
      end
    end else begin
      want = due_responses.pop_front();
      bad = (got.read_data   !== want.read_data)   || (got.pal_valid   !== want.pal_valid)   ||
            (got.pal_index   !== want.pal_index)   || (got.red         !== want.red)         ||
            (got.green       !== want.green)       || (got.blue        !== want.blue)        ||
            (got.dirty_valid !== want.dirty_valid) || (got.dirty_layer !== want.dirty_layer) ||
            (got.dirty_tile  !== want.dirty_tile)  || (got.tile_code   !== want.tile_code)   ||
            (got.tile_color  !== want.tile_color);
      if (bad) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("ERROR: mismatch at %0t", $realtime);
          $display("  expected %s", rsp_text(want));
          $display("  actual   %s", rsp_text(got));
        end
      end
    end
  endtask

  // Result side: random stall before each result, none while idle_off is set.
  initial begin
    int        stall;
    vram_rsp_t got;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_off ? 0 : $urandom_range(0, 16);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.read_data   = out_read_data;
      got.pal_valid   = out_pal_valid;
      got.pal_index   = out_pal_index;
      got.red         = out_red;
      got.green       = out_green;
      got.blue        = out_blue;
      got.dirty_valid = out_dirty_valid;
      got.dirty_layer = out_dirty_layer;
      got.dirty_tile  = out_dirty_tile;
      got.tile_code   = out_tile_code;
      got.tile_color  = out_tile_color;
      check_response(got);
    end
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    vram_rsp_t zero_rsp;
    zero_rsp       = '0;
    fail_count     = 0;
    idle_off       = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = CMD_READ;
    in_offset      = '0;
    in_data        = '0;
    in_fetch_layer = 1'b0;
    in_tile_index  = '0;
    out_ready      = 1'b0;
    shadow_bank    = '0;
    for (int i = 0; i < MEM_BYTES; i++) begin
      shadow_a[i] = '0;
      shadow_b[i] = '0;
    end
    tile_pool[0] = '0;
    tile_pool[1] = TILE_AW'(MAP_TILES - 1);
    for (int i = 2; i < 8; i++) begin
      tile_pool[i] = TILE_AW'($urandom_range(0, MAP_TILES - 1));
    end

    // Both memories read as zero after reset.
    add_row(CMD_READ,  13'h0000, 8'h00, 1'b0, 11'h000, 1, zero_rsp);
    add_row(CMD_READ,  13'h1fff, 8'hff, 1'b1, 11'h7ff, 1, zero_rsp);
    add_row(CMD_FETCH, 13'h0000, 8'h00, 1'b0, 11'h000, 1, zero_rsp);
    add_row(CMD_FETCH, 13'h1fff, 8'hff, 1'b1, 11'h7ff, 1, zero_rsp);
    // Palette pair in memory B, then white.
    add_row(CMD_WRITE, 13'h0000, 8'hff, 1'b0, 11'h000, 0, zero_rsp);
    add_row(CMD_WRITE, 13'h0001, 8'h7f, 1'b1, 11'h7ff, 0, zero_rsp);
    add_row(CMD_READ,  13'h0001, 8'h00, 1'b0, 11'h000, 0, zero_rsp);
    add_row(CMD_BANK,  13'h1fff, 8'h03, 1'b1, 11'h7ff, 1, zero_rsp);
    add_row(CMD_WRITE, 13'h07ff, 8'hff, 1'b0, 11'h000, 0, zero_rsp);
    add_row(CMD_WRITE, 13'h07fe, 8'h00, 1'b0, 11'h000, 0, zero_rsp);
    add_row(CMD_WRITE, 13'h0800, 8'h3f, 1'b0, 11'h000, 1, dirty_rsp(1'b0, 11'h000));
    add_row(CMD_WRITE, 13'h0fff, 8'hff, 1'b1, 11'h7ff, 1, dirty_rsp(1'b0, 11'h7ff));
    add_row(CMD_WRITE, 13'h1000, 8'h34, 1'b0, 11'h000, 1, dirty_rsp(1'b0, 11'h000));
    add_row(CMD_WRITE, 13'h1001, 8'h12, 1'b0, 11'h000, 1, dirty_rsp(1'b0, 11'h000));
    add_row(CMD_FETCH, 13'h0000, 8'h00, 1'b0, 11'h000, 0, zero_rsp);
    // Only the low two of the eight bank bits are stored in the block; they alone matter.
    add_row(CMD_BANK,  13'h0000, 8'hfe, 1'b0, 11'h000, 1, zero_rsp);
    add_row(CMD_WRITE, 13'h1ffe, 8'haa, 1'b0, 11'h000, 1, dirty_rsp(1'b1, 11'h7ff));
    add_row(CMD_WRITE, 13'h1fff, 8'h55, 1'b0, 11'h000, 1, dirty_rsp(1'b1, 11'h7ff));
    add_row(CMD_WRITE, 13'h0fff, 8'hff, 1'b0, 11'h000, 1, dirty_rsp(1'b1, 11'h7ff));
    add_row(CMD_FETCH, 13'h0000, 8'h00, 1'b1, 11'h7ff, 0, zero_rsp);
    add_row(CMD_FETCH, 13'h0000, 8'h00, 1'b0, 11'h7ff, 0, zero_rsp);
    add_row(CMD_READ,  13'h0fff, 8'h00, 1'b0, 11'h000, 0, zero_rsp);
    add_row(CMD_READ,  13'h07ff, 8'h00, 1'b0, 11'h000, 0, zero_rsp);
    add_row(CMD_BANK,  13'h0000, 8'h01, 1'b0, 11'h000, 1, zero_rsp);
    add_row(CMD_READ,  13'h0fff, 8'h00, 1'b0, 11'h000, 0, zero_rsp);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
    end
    // Hold off each request phase until the previous one has fully drained.
    drain_responses();

    for (int phase = 0; phase < 5; phase++) begin
      idle_off = (phase == 2);
      repeat (170) begin
        send_request(random_req(), 0, zero_rsp);
      end
      drain_responses();
    end
    idle_off = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    drain_responses();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && due_responses.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
